/* hw/rtl/sts_pkg.sv */
// ----------------------------------------------------------------------------
// Sine Taylor series package
// Shared constants, datapath operation codes and the command and status
// types that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sts_pkg;

    // Fixed field widths of the block's ports.
    localparam int ANGLE_W = 32;
    localparam int THR_W   = 29;
    localparam int TERMS_W = 5;

    // Datapath operation codes.
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_SQ_LO  = 4'd2;
    localparam logic [3:0] OP_SQ_HI  = 4'd3;
    localparam logic [3:0] OP_X2     = 4'd4;
    localparam logic [3:0] OP_ACC    = 4'd5;
    localparam logic [3:0] OP_MUL_LO = 4'd6;
    localparam logic [3:0] OP_MUL_HI = 4'd7;
    localparam logic [3:0] OP_REC_LO = 4'd8;
    localparam logic [3:0] OP_REC_HI = 4'd9;
    localparam logic [3:0] OP_BACK   = 4'd10;
    localparam logic [3:0] OP_FIX    = 4'd11;
    localparam logic [3:0] OP_FINISH = 4'd12;

    // Command from the controller: the operation and, for an accumulate,
    // whether the newest term is subtracted.
    typedef struct packed {
        logic [3:0] op;
        logic       sub;
    } t_dp_cmd;

    // Status back to the controller.
    typedef struct packed {
        logic below_thr;
    } t_dp_stat;

endpackage

/* hw/rtl/sts_datapath.sv */
// ----------------------------------------------------------------------------
// Sine Taylor series datapath
// Holds the angle, its square, the running term and the sum. One shared
// multiplier works in halves; division by (2k)(2k+1) uses a reciprocal
// table followed by a single correction step.
// ----------------------------------------------------------------------------
module sts_datapath #(
    parameter int FRAC_BITS = 28,
    parameter int MAX_TERMS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  sts_pkg::t_dp_cmd                      i_cmd,
    input  logic [$clog2(MAX_TERMS)-1:0]          i_term_idx,
    input  logic signed [sts_pkg::ANGLE_W-1:0]    i_angle,
    input  logic                                  i_thr_we,
    input  logic [sts_pkg::THR_W-1:0]             i_thr_data,
    output sts_pkg::t_dp_stat                     o_stat,
    output logic signed [FRAC_BITS+1:0]           o_sine
);
    import sts_pkg::*;

    // Widths: |x| <= 4, terms < 11, x^2 <= 16, products before division < 176.
    localparam int AXW  = FRAC_BITS + 3;
    localparam int CW   = FRAC_BITS + 4;
    localparam int XW   = FRAC_BITS + 5;
    localparam int QW   = FRAC_BITS + 8;
    localparam int RW   = QW - 2;
    localparam int SW   = FRAC_BITS + 5;
    localparam int OW   = FRAC_BITS + 2;
    localparam int IW   = $clog2(MAX_TERMS);
    localparam int DMAX = 2 * MAX_TERMS * (2 * MAX_TERMS + 1);
    localparam int DW   = $clog2(DMAX + 1);
    localparam int BH0  = (RW + 1) / 2;
    localparam int BH   = (BH0 > DW) ? BH0 : DW;
    localparam int PW   = QW + BH;
    localparam int AW   = QW + 2 * BH;
    localparam int EW   = (AXW > ANGLE_W + 1) ? AXW : ANGLE_W + 1;
    localparam int CMPW = (CW > THR_W) ? CW : THR_W;

    localparam logic [EW-1:0]        LIM       = EW'(64'd4 << FRAC_BITS);
    localparam logic signed [SW-1:0] ONE_S     = SW'(64'd1 << FRAC_BITS);
    localparam logic [THR_W-1:0]     THR_RESET = THR_W'(((64'd1 << FRAC_BITS) + 5000) / 10000);

    // Divisor and reciprocal tables, one entry per term.
    logic [DW-1:0] w_d_tab [MAX_TERMS];
    logic [RW-1:0] w_r_tab [MAX_TERMS];

    genvar g;
    generate
        for (g = 0; g < MAX_TERMS; g++) begin : g_tab
            localparam longint unsigned D_G = (2 * (g + 1)) * (2 * (g + 1) + 1);
            localparam longint unsigned R_G = (64'd1 << QW) / D_G;
            assign w_d_tab[g] = DW'(D_G);
            assign w_r_tab[g] = RW'(R_G);
        end
    endgenerate

    logic [AXW-1:0]        r_ax;
    logic                  r_neg;
    logic [XW-1:0]         r_x2;
    logic [CW-1:0]         r_cur;
    logic [QW-1:0]         r_q;
    logic [RW-1:0]         r_est;
    logic [AW-1:0]         r_acc;
    logic signed [SW-1:0]  r_sum;
    logic [OW-1:0]         r_sine;
    logic [THR_W-1:0]      r_stop_thr;

    logic signed [EW-1:0]  w_ang_ext;
    logic [EW-1:0]         w_abs;
    logic [EW-1:0]         w_ax_clamp;
    logic [AXW-1:0]        w_ax;
    logic [2*BH-1:0]       w_ax_w;
    logic [2*BH-1:0]       w_x2_w;
    logic [2*BH-1:0]       w_r_w;
    logic [DW-1:0]         w_d;
    logic [QW-1:0]         w_q_now;
    logic [RW-1:0]         w_est_now;
    logic [QW-1:0]         w_mul_a;
    logic [BH-1:0]         w_mul_b;
    logic [PW-1:0]         w_prod;
    logic [QW-1:0]         w_rem;
    logic                  w_fix;
    logic [CW-1:0]         w_cur_new;
    logic signed [SW-1:0]  w_cur_s;
    logic signed [SW-1:0]  w_signed;
    logic signed [SW-1:0]  w_sat;

    // Magnitude of the angle, clamped to 4.0.
    assign w_ang_ext  = EW'(i_angle);
    assign w_abs      = w_ang_ext[EW-1] ? EW'(-w_ang_ext) : EW'(w_ang_ext);
    assign w_ax_clamp = (w_abs > LIM) ? LIM : w_abs;
    assign w_ax       = w_ax_clamp[AXW-1:0];

    // Operands split into halves for the shared multiplier.
    assign w_ax_w    = (2*BH)'(r_ax);
    assign w_x2_w    = (2*BH)'(r_x2);
    assign w_r_w     = (2*BH)'(w_r_tab[i_term_idx]);
    assign w_d       = w_d_tab[i_term_idx];
    assign w_q_now   = r_acc[FRAC_BITS +: QW];
    assign w_est_now = r_acc[QW +: RW];

    // Operand selection for the shared multiplier.
    always_comb begin
        case (i_cmd.op)
            OP_SQ_LO: begin
                w_mul_a = QW'(r_ax);
                w_mul_b = w_ax_w[BH-1:0];
            end
            OP_SQ_HI: begin
                w_mul_a = QW'(r_ax);
                w_mul_b = w_ax_w[2*BH-1:BH];
            end
            OP_MUL_LO: begin
                w_mul_a = QW'(r_cur);
                w_mul_b = w_x2_w[BH-1:0];
            end
            OP_MUL_HI: begin
                w_mul_a = QW'(r_cur);
                w_mul_b = w_x2_w[2*BH-1:BH];
            end
            OP_REC_LO: begin
                w_mul_a = w_q_now;
                w_mul_b = w_r_w[BH-1:0];
            end
            OP_REC_HI: begin
                w_mul_a = r_q;
                w_mul_b = w_r_w[2*BH-1:BH];
            end
            OP_BACK: begin
                w_mul_a = QW'(w_est_now);
                w_mul_b = BH'(w_d);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = PW'(w_mul_a) * PW'(w_mul_b);

    // The reciprocal estimate is at most one short; the remainder tells.
    assign w_rem     = r_q - r_acc[QW-1:0];
    assign w_fix     = (w_rem >= QW'(w_d));
    assign w_cur_new = CW'(r_est) + CW'(w_fix);
    assign w_cur_s   = $signed({{(SW-CW){1'b0}}, r_cur});

    // Sign applied to the sum, then saturation to plus or minus one.
    assign w_signed = r_neg ? -r_sum : r_sum;
    always_comb begin
        if (w_signed > ONE_S) begin
            w_sat = ONE_S;
        end else if (w_signed < -ONE_S) begin
            w_sat = -ONE_S;
        end else begin
            w_sat = w_signed;
        end
    end

    // Product accumulator: low halves and the back multiply load it, high halves add in shifted.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op inside {OP_SQ_LO, OP_MUL_LO, OP_REC_LO, OP_BACK}) begin
            r_acc <= AW'(w_prod);
        end else if (i_cmd.op inside {OP_SQ_HI, OP_MUL_HI, OP_REC_HI}) begin
            r_acc <= r_acc + (AW'(w_prod) << BH);
        end
    end

    // Operand, term and sum registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_ax  <= w_ax;
                r_neg <= i_angle[ANGLE_W-1];
                r_cur <= CW'(w_ax);
                r_sum <= $signed({{(SW-AXW){1'b0}}, w_ax});
            end
            OP_X2: begin
                r_x2 <= r_acc[FRAC_BITS +: XW];
            end
            OP_REC_LO: begin
                r_q <= w_q_now;
            end
            OP_BACK: begin
                r_est <= w_est_now;
            end
            OP_FIX: begin
                r_cur <= w_cur_new;
            end
            OP_ACC: begin
                if (i_cmd.sub) begin
                    r_sum <= r_sum - w_cur_s;
                end else begin
                    r_sum <= r_sum + w_cur_s;
                end
            end
            OP_FINISH: begin
                r_sine <= w_sat[OW-1:0];
            end
            default: begin
            end
        endcase
    end

    // Stop threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_thr <= THR_RESET;
        end else if (i_thr_we) begin
            r_stop_thr <= i_thr_data;
        end
    end

    assign o_stat.below_thr = (CMPW'(r_cur) < CMPW'(r_stop_thr));
    assign o_sine           = $signed(r_sine);

endmodule

/* hw/rtl/sts_ctrl.sv */
// ----------------------------------------------------------------------------
// Sine Taylor series controller
// Sequences the datapath through squaring the angle and then one pass of
// seven steps per Taylor term, and registers the result strobe.
// ----------------------------------------------------------------------------
module sts_ctrl #(
    parameter int MAX_TERMS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  sts_pkg::t_dp_stat                 i_stat,
    output logic                              o_busy,
    output sts_pkg::t_dp_cmd                  o_cmd,
    output logic [$clog2(MAX_TERMS)-1:0]      o_term_idx,
    output logic                              o_strobe,
    output logic [sts_pkg::TERMS_W-1:0]       o_terms_used,
    output logic                              o_hit_limit
);
    import sts_pkg::*;

    localparam int KW = $clog2(MAX_TERMS + 1);
    localparam int IW = $clog2(MAX_TERMS);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SQ_LO  = 4'd1;
    localparam logic [3:0] S_SQ_HI  = 4'd2;
    localparam logic [3:0] S_X2     = 4'd3;
    localparam logic [3:0] S_CHECK  = 4'd4;
    localparam logic [3:0] S_MUL_LO = 4'd5;
    localparam logic [3:0] S_MUL_HI = 4'd6;
    localparam logic [3:0] S_REC_LO = 4'd7;
    localparam logic [3:0] S_REC_HI = 4'd8;
    localparam logic [3:0] S_BACK   = 4'd9;
    localparam logic [3:0] S_FIX    = 4'd10;
    localparam logic [3:0] S_FINISH = 4'd11;

    logic [3:0]         r_state;
    logic [3:0]         n_state;
    logic [KW-1:0]      r_k;
    logic [KW-1:0]      n_k;
    logic               r_limit;
    logic               n_limit;
    logic               r_strobe;
    logic [TERMS_W-1:0] r_terms;
    logic               r_hit;
    logic               w_at_max;
    logic [KW+TERMS_W-1:0] w_k_ext;

    assign w_at_max = (r_k == KW'(MAX_TERMS));
    assign w_k_ext  = {{TERMS_W{1'b0}}, r_k};

    // Next state, term count and datapath command.
    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_limit   = r_limit;
        o_cmd.op  = OP_NONE;
        o_cmd.sub = r_k[0];
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_LOAD;
                    n_k      = '0;
                    n_limit  = 1'b0;
                    n_state  = S_SQ_LO;
                end
            end
            S_SQ_LO: begin
                o_cmd.op = OP_SQ_LO;
                n_state  = S_SQ_HI;
            end
            S_SQ_HI: begin
                o_cmd.op = OP_SQ_HI;
                n_state  = S_X2;
            end
            S_X2: begin
                o_cmd.op = OP_X2;
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                // Add the term just made, then decide whether to go on.
                if (r_k != '0) begin
                    o_cmd.op = OP_ACC;
                end
                if (i_stat.below_thr) begin
                    n_state = S_FINISH;
                end else if (w_at_max) begin
                    n_limit = 1'b1;
                    n_state = S_FINISH;
                end else begin
                    n_state = S_MUL_LO;
                end
            end
            S_MUL_LO: begin
                o_cmd.op = OP_MUL_LO;
                n_state  = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.op = OP_MUL_HI;
                n_state  = S_REC_LO;
            end
            S_REC_LO: begin
                o_cmd.op = OP_REC_LO;
                n_state  = S_REC_HI;
            end
            S_REC_HI: begin
                o_cmd.op = OP_REC_HI;
                n_state  = S_BACK;
            end
            S_BACK: begin
                o_cmd.op = OP_BACK;
                n_state  = S_FIX;
            end
            S_FIX: begin
                o_cmd.op = OP_FIX;
                n_k      = r_k + KW'(1);
                n_state  = S_CHECK;
            end
            S_FINISH: begin
                o_cmd.op = OP_FINISH;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= '0;
            r_limit  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_limit  <= n_limit;
            r_strobe <= (r_state == S_FINISH);
        end
    end

    // Term count and limit flag result registers, loaded in the finishing cycle together with the sine.
    always_ff @(posedge i_clk) begin
        if (r_state == S_FINISH) begin
            r_terms <= w_k_ext[TERMS_W-1:0];
            r_hit   <= r_limit;
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_term_idx   = r_k[IW-1:0];
    assign o_strobe     = r_strobe;
    assign o_terms_used = r_terms;
    assign o_hit_limit  = r_hit;

    // The term count never passes the limit.
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= KW'(MAX_TERMS))
        else $error("term count beyond limit");

    // A strobe lasts one cycle.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |=> !r_strobe)
        else $error("result strobe held for more than one cycle");

    // The limit flag is only raised with the full term count.
    a_limit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_limit |-> w_at_max)
        else $error("limit flagged before all terms were added");

    // A new term is only started while below the limit.
    a_term_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL_LO) |-> !w_at_max)
        else $error("term started at the limit");

endmodule

/* hw/rtl/sine_taylor_series.sv */
// ----------------------------------------------------------------------------
// Sine Taylor series
// Computes sin(x) for a signed Q3.28 angle by summing Taylor terms until a
// term falls below a programmable threshold or the term limit is reached.
// ----------------------------------------------------------------------------
// Usage:
// An angle on i_angle is taken at a rising edge with start high and busy
// low. busy stays high while the series is summed. The result appears on
// o_sine, o_terms_used and o_hit_limit, marked by o_strobe high for exactly
// one cycle; the receiver cannot stall it and must take it in that cycle.
// Each term is made on the one shared multiplier: two halves of the
// multiply by x squared, two halves of the reciprocal multiply, the back
// multiply, the quotient correction and the accumulate with the stop test.
// Squaring the angle comes first, once per transaction.
// A new angle may be accepted in the strobe cycle itself.
// The stop threshold is written through i_cfg_valid / o_cfg_ready and
// i_cfg_data while the block is idle. Reset is synchronous and active low;
// it returns the controller to idle and the threshold to 0.0001.
// ----------------------------------------------------------------------------
module sine_taylor_series #(
    parameter int FRAC_BITS = 28,
    parameter int MAX_TERMS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [sts_pkg::ANGLE_W-1:0]  i_angle,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sts_pkg::THR_W-1:0]           i_cfg_data,
    output logic                                o_strobe,
    output logic signed [FRAC_BITS+1:0]         o_sine,
    output logic [sts_pkg::TERMS_W-1:0]         o_terms_used,
    output logic                                o_hit_limit
);
    import sts_pkg::*;

    t_dp_cmd                      w_cmd;
    t_dp_stat                     w_stat;
    logic [$clog2(MAX_TERMS)-1:0] w_term_idx;
    logic                         w_busy;
    logic                         w_thr_we;

    // The threshold is taken whenever no transaction is in progress.
    assign o_cfg_ready = ~w_busy;
    assign w_thr_we    = i_cfg_valid & ~w_busy;
    assign busy        = w_busy;

    sts_ctrl #(
        .MAX_TERMS (MAX_TERMS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_stat       (w_stat),
        .o_busy       (w_busy),
        .o_cmd        (w_cmd),
        .o_term_idx   (w_term_idx),
        .o_strobe     (o_strobe),
        .o_terms_used (o_terms_used),
        .o_hit_limit  (o_hit_limit)
    );

    sts_datapath #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_TERMS (MAX_TERMS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_term_idx (w_term_idx),
        .i_angle    (i_angle),
        .i_thr_we   (w_thr_we),
        .i_thr_data (i_cfg_data),
        .o_stat     (w_stat),
        .o_sine     (o_sine)
    );

endmodule
